@@ rtl/hsvg_pkg.sv @@
// Hemisphere strip vertex generator: shared types, constants and tables.
// The quarter-wave sine table and texture tables are built at elaboration.
// No dependencies.
`default_nettype none

package hsvg_pkg;

    // Geometry and number formats
    localparam int SPHERE_RADIUS  = 450;
    localparam int SINE_FRAC_BITS = 15;
    localparam int RADIUS_W       = 11;
    localparam int SINE_W         = SINE_FRAC_BITS + 1;
    localparam int RS_W           = RADIUS_W + SINE_W;
    localparam int PROD_W         = RS_W + SINE_W;
    localparam int XY_SHIFT       = 2 * SINE_FRAC_BITS - 4;
    localparam int Z_SHIFT        = SINE_FRAC_BITS - 4;
    localparam int COORD_W        = 14;
    localparam int TEX_W          = 17;
    localparam int AZ_W           = 9;
    localparam int EL_W           = 7;
    localparam int ANGLE_W        = 10;
    localparam int IDX_W          = 7;
    localparam int TDATA_IN_W     = 8;
    localparam int TDATA_OUT_W    = 80;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 9;
    localparam int STEP_W         = 4;

    localparam int FULL_TURN      = 360;
    localparam int HALF_TURN      = 180;
    localparam int QUARTER_TURN   = 90;
    localparam int THREE_QUARTER  = 270;
    localparam int COORD_POS_MAX  = 8191;
    localparam int COORD_NEG_MAX  = 8192;
    localparam int TEX_ONE        = 65536;
    localparam int STEP_RESET     = 10;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_AZIMUTH_STEP   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ELEVATION_STEP = 1'b1;

    // Sequencer steps: one product per step, consumed one step later
    localparam logic [STEP_W-1:0] STEP_R_SA  = 4'd0;
    localparam logic [STEP_W-1:0] STEP_R_CA  = 4'd1;
    localparam logic [STEP_W-1:0] STEP_Z_LO  = 4'd2;
    localparam logic [STEP_W-1:0] STEP_Z_HI  = 4'd3;
    localparam logic [STEP_W-1:0] STEP_X_LO  = 4'd4;
    localparam logic [STEP_W-1:0] STEP_Y_LO  = 4'd5;
    localparam logic [STEP_W-1:0] STEP_X_HI  = 4'd6;
    localparam logic [STEP_W-1:0] STEP_Y_HI  = 4'd7;
    localparam logic [STEP_W-1:0] STEP_DRAIN = 4'd8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_OUT_LO,
        ST_OUT_HI
    } state_t;

    typedef struct packed {
        logic              neg;
        logic [SINE_W-1:0] mag;
    } sine_t;

    typedef logic [SINE_W-1:0] sine_rom_t [0:QUARTER_TURN];
    typedef logic [TEX_W-1:0]  tex_s_rom_t [0:QUARTER_TURN-1];
    typedef logic [TEX_W-1:0]  tex_t_rom_t [0:QUARTER_TURN];

    // Divide a Taylor term by (2k)(2k+1), one fixed divisor per term
    function automatic longint unsigned taylor_divide(input longint unsigned term,
                                                      input int k);
        longint unsigned q;
        case (k)
            1:       q = term / 64'd6;
            2:       q = term / 64'd20;
            3:       q = term / 64'd42;
            4:       q = term / 64'd72;
            5:       q = term / 64'd110;
            6:       q = term / 64'd156;
            7:       q = term / 64'd210;
            8:       q = term / 64'd272;
            9:       q = term / 64'd342;
            10:      q = term / 64'd420;
            11:      q = term / 64'd506;
            12:      q = term / 64'd600;
            13:      q = term / 64'd702;
            default: q = term / 64'd812;
        endcase
        return q;
    endfunction

    // Taylor series of sin in Q30, rounded half up to SINE_FRAC_BITS
    function automatic sine_rom_t build_sine_rom();
        sine_rom_t       rom;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned pos;
        longint unsigned negs;
        longint unsigned v;
        for (int d = 0; d <= QUARTER_TURN; d++) begin
            x    = (longint'(d) * 64'd3373259426 + 64'd90) / 64'd180;
            x2   = (x * x + (64'd1 << 29)) >> 30;
            term = x;
            pos  = x;
            negs = 64'd0;
            for (int k = 1; k <= 14; k++) begin
                term = (term * x2) >> 30;
                term = taylor_divide(term, k);
                if ((k % 2) == 1) begin
                    negs = negs + term;
                end else begin
                    pos = pos + term;
                end
            end
            v = (pos > negs) ? pos - negs : 64'd0;
            if (v > (64'd1 << 30)) begin
                v = 64'd1 << 30;
            end
            v = (v + (64'd1 << (29 - SINE_FRAC_BITS))) >> (30 - SINE_FRAC_BITS);
            rom[d] = SINE_W'(v);
        end
        return rom;
    endfunction

    // Fraction of a full turn of azimuth, rounded to Q16
    function automatic tex_s_rom_t build_tex_s_rom();
        tex_s_rom_t rom;
        for (int b = 0; b < QUARTER_TURN; b++) begin
            rom[b] = TEX_W'((b * TEX_ONE + HALF_TURN / 2 * 2) / FULL_TURN);
        end
        return rom;
    endfunction

    // Elevation over a quarter turn, rounded to Q16
    function automatic tex_t_rom_t build_tex_t_rom();
        tex_t_rom_t rom;
        for (int p = 0; p <= QUARTER_TURN; p++) begin
            rom[p] = TEX_W'((p * TEX_ONE + QUARTER_TURN / 2) / QUARTER_TURN);
        end
        return rom;
    endfunction

    localparam sine_rom_t  SINE_ROM  = build_sine_rom();
    localparam tex_s_rom_t TEX_S_ROM = build_tex_s_rom();
    localparam tex_t_rom_t TEX_T_ROM = build_tex_t_rom();

    // Fold an angle of up to 450 degrees onto the quarter-wave table
    function automatic sine_t sine_lookup(input logic [ANGLE_W-1:0] angle);
        logic [ANGLE_W-1:0] a;
        logic [ANGLE_W-1:0] idx;
        sine_t              r;
        a = (angle >= ANGLE_W'(FULL_TURN)) ? angle - ANGLE_W'(FULL_TURN) : angle;
        if (a <= ANGLE_W'(QUARTER_TURN)) begin
            idx   = a;
            r.neg = 1'b0;
        end else if (a <= ANGLE_W'(HALF_TURN)) begin
            idx   = ANGLE_W'(HALF_TURN) - a;
            r.neg = 1'b0;
        end else if (a <= ANGLE_W'(THREE_QUARTER)) begin
            idx   = a - ANGLE_W'(HALF_TURN);
            r.neg = 1'b1;
        end else begin
            idx   = ANGLE_W'(FULL_TURN) - a;
            r.neg = 1'b1;
        end
        if (idx == '0) begin
            r.neg = 1'b0;
        end
        r.mag = SINE_ROM[idx[IDX_W-1:0]];
        return r;
    endfunction

    // Texture s: one minus azimuth over a full turn, via quadrant split
    function automatic logic [TEX_W-1:0] tex_s_of(input logic [AZ_W-1:0] theta);
        logic [2:0]       quad;
        logic [AZ_W-1:0]  b;
        logic [TEX_W-1:0] base;
        if (theta >= AZ_W'(FULL_TURN)) begin
            quad = 3'd4;
            b    = theta - AZ_W'(FULL_TURN);
        end else if (theta >= AZ_W'(THREE_QUARTER)) begin
            quad = 3'd3;
            b    = theta - AZ_W'(THREE_QUARTER);
        end else if (theta >= AZ_W'(HALF_TURN)) begin
            quad = 3'd2;
            b    = theta - AZ_W'(HALF_TURN);
        end else if (theta >= AZ_W'(QUARTER_TURN)) begin
            quad = 3'd1;
            b    = theta - AZ_W'(QUARTER_TURN);
        end else begin
            quad = 3'd0;
            b    = theta;
        end
        base = TEX_W'(quad) << 14;
        return TEX_W'(TEX_ONE) - (base + TEX_S_ROM[b[IDX_W-1:0]]);
    endfunction

    // Round a product magnitude to Q10.4, saturate, encode two's complement
    function automatic logic [COORD_W-1:0] to_coord(input logic [PROD_W-1:0] prod,
                                                    input logic is_z,
                                                    input logic neg);
        logic [PROD_W:0] sum_xy;
        logic [PROD_W:0] sum_z;
        logic [PROD_W:0] mag;
        sum_xy = {1'b0, prod} + ((PROD_W+1)'(1) << (XY_SHIFT - 1));
        sum_z  = {1'b0, prod} + ((PROD_W+1)'(1) << (Z_SHIFT - 1));
        mag    = is_z ? (sum_z >> Z_SHIFT) : (sum_xy >> XY_SHIFT);
        if (neg) begin
            if (mag > (PROD_W+1)'(COORD_NEG_MAX)) begin
                mag = (PROD_W+1)'(COORD_NEG_MAX);
            end
            return COORD_W'(0) - mag[COORD_W-1:0];
        end
        if (mag > (PROD_W+1)'(COORD_POS_MAX)) begin
            mag = (PROD_W+1)'(COORD_POS_MAX);
        end
        return mag[COORD_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ rtl/hemisphere_strip_vertex_generator_unit.sv @@
// Hemisphere strip vertex generator: angle stepping, shared multiplier
// sequencer and two-beat vertex output. Depends on hsvg_pkg.
`default_nettype none

// An accepted item that emits a pair runs the sequencer steps, then raises m_tvalid
// for the lower vertex; the upper vertex is offered in the cycle after the lower one
// is taken. The next request is accepted only after the upper vertex is taken; the
// rate is set by the 9-step schedule of the single 27x16 multiplier plus the two
// output beats and any output stall; an item that emits nothing leaves the unit idle.
// Reset (synchronous, aresetn low): counters and done state clear, both steps 10.
module hemisphere_strip_vertex_generator_unit (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // configuration write port
    input  wire logic                                 cfg_we,
    input  wire logic [hsvg_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [hsvg_pkg::CFG_DATA_W-1:0]      cfg_data,
    // request channel
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [hsvg_pkg::TDATA_IN_W-1:0]      s_tdata,   // restart
    // vertex channel
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // pos_x, pos_y, pos_z, tex_s, tex_t
    output logic [hsvg_pkg::TDATA_OUT_W-1:0]          m_tdata,
    output logic                                      m_tlast,   // pair_last
    output logic                                      m_tuser    // mesh_done
);

    localparam int CW = hsvg_pkg::COORD_W;
    localparam int TW = hsvg_pkg::TEX_W;

    // control state
    hsvg_pkg::state_t                  state_reg, state_next;
    logic [hsvg_pkg::STEP_W-1:0]       step_reg, step_next;
    logic [hsvg_pkg::AZ_W-1:0]         az_step_reg, az_step_next;
    logic [hsvg_pkg::EL_W-1:0]         el_step_reg, el_step_next;
    logic [hsvg_pkg::AZ_W-1:0]         az_reg, az_next;
    logic [hsvg_pkg::EL_W-1:0]         el_reg, el_next;
    logic                              fin_reg, fin_next;

    // per-item work registers
    logic [hsvg_pkg::AZ_W-1:0]         theta_reg;
    logic [hsvg_pkg::EL_W-1:0]         phi_reg;
    logic [hsvg_pkg::EL_W-1:0]         phi2_reg;
    logic                              done_reg;
    logic [hsvg_pkg::PROD_W-1:0]       prod_reg;
    logic                              prod_neg_reg;
    logic [hsvg_pkg::RS_W-1:0]         rsa_reg;
    logic [hsvg_pkg::RS_W-1:0]         rca_reg;
    logic                              na_reg;
    logic                              nc_reg;
    logic [CW-1:0]                     x0_reg, y0_reg, z0_reg;
    logic [CW-1:0]                     x1_reg, y1_reg, z1_reg;
    logic [TW-1:0]                     tex_s_reg, tex_t0_reg, tex_t1_reg;

    // request decode
    logic                              accept;
    logic                              restart;
    logic [hsvg_pkg::AZ_W-1:0]         az_eff;
    logic [hsvg_pkg::EL_W-1:0]         el_eff;
    logic                              fin_eff;
    logic [hsvg_pkg::AZ_W-1:0]         da;
    logic [hsvg_pkg::EL_W-1:0]         de;
    logic [hsvg_pkg::EL_W:0]           el_sum;
    logic [hsvg_pkg::EL_W+1:0]         el_sum2;
    logic [hsvg_pkg::AZ_W:0]           az_sum;
    logic                              out_of_range;
    logic                              wrap;
    logic                              last_ring;
    logic                              emit;

    // shared unit operands
    logic [hsvg_pkg::ANGLE_W-1:0]      angle_sel;
    hsvg_pkg::sine_t                   sine;
    logic [hsvg_pkg::RS_W-1:0]         mul_a;
    logic                              neg_mod;
    logic [hsvg_pkg::PROD_W-1:0]       mul_prod;
    logic [CW-1:0]                     coord;
    logic                              coord_is_z;

    assign accept  = s_tvalid && s_tready;
    assign restart = s_tdata[0];
    assign az_eff  = restart ? '0 : az_reg;
    assign el_eff  = restart ? '0 : el_reg;
    assign fin_eff = restart ? 1'b0 : fin_reg;
    assign da      = (az_step_reg == '0) ? hsvg_pkg::AZ_W'(1) : az_step_reg;
    assign de      = (el_step_reg == '0) ? hsvg_pkg::EL_W'(1) : el_step_reg;
    assign el_sum  = {1'b0, el_eff} + {1'b0, de};
    assign el_sum2 = {1'b0, el_sum} + {2'b00, de};
    assign az_sum  = {1'b0, az_eff} + {1'b0, da};

    assign out_of_range = (el_sum > (hsvg_pkg::EL_W+1)'(hsvg_pkg::QUARTER_TURN))
                       || (az_eff > hsvg_pkg::AZ_W'(hsvg_pkg::FULL_TURN));
    assign wrap      = az_sum > (hsvg_pkg::AZ_W+1)'(hsvg_pkg::FULL_TURN);
    assign last_ring = el_sum2 > (hsvg_pkg::EL_W+2)'(hsvg_pkg::QUARTER_TURN);
    assign emit      = accept && !fin_eff && !out_of_range;

    // Next state of the sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            hsvg_pkg::ST_IDLE: begin
                if (emit) begin
                    state_next = hsvg_pkg::ST_CALC;
                end
            end
            hsvg_pkg::ST_CALC: begin
                if (step_reg == hsvg_pkg::STEP_DRAIN) begin
                    state_next = hsvg_pkg::ST_OUT_LO;
                end
            end
            hsvg_pkg::ST_OUT_LO: begin
                if (m_tready) begin
                    state_next = hsvg_pkg::ST_OUT_HI;
                end
            end
            hsvg_pkg::ST_OUT_HI: begin
                if (m_tready) begin
                    state_next = hsvg_pkg::ST_IDLE;
                end
            end
            default: state_next = hsvg_pkg::ST_IDLE;
        endcase
    end

    // Handshake and payload outputs
    always_comb begin
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        m_tlast  = 1'b0;
        m_tuser  = done_reg;
        m_tdata  = {4'b0000, tex_t0_reg, tex_s_reg, z0_reg, y0_reg, x0_reg};
        unique case (state_reg)
            hsvg_pkg::ST_IDLE: begin
                s_tready = 1'b1;
            end
            hsvg_pkg::ST_CALC: begin
                s_tready = 1'b0;
            end
            hsvg_pkg::ST_OUT_LO: begin
                m_tvalid = 1'b1;
            end
            hsvg_pkg::ST_OUT_HI: begin
                m_tvalid = 1'b1;
                m_tlast  = 1'b1;
                m_tdata  = {4'b0000, tex_t1_reg, tex_s_reg, z1_reg, y1_reg, x1_reg};
            end
            default: s_tready = 1'b0;
        endcase
    end

    // Step counter, angle counters, done state and configuration
    always_comb begin
        step_next    = (state_reg == hsvg_pkg::ST_CALC) ? step_reg + 1'b1 : '0;
        az_step_next = az_step_reg;
        el_step_next = el_step_reg;
        az_next      = az_reg;
        el_next      = el_reg;
        fin_next     = fin_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                hsvg_pkg::CFG_AZIMUTH_STEP:   az_step_next = cfg_data;
                hsvg_pkg::CFG_ELEVATION_STEP: el_step_next = cfg_data[hsvg_pkg::EL_W-1:0];
                default:                      az_step_next = az_step_reg;
            endcase
        end
        if (accept) begin
            // restart clears first; a finished or ill-fitting ring emits nothing
            az_next  = az_eff;
            el_next  = el_eff;
            fin_next = fin_eff;
            if (!fin_eff) begin
                if (out_of_range || (wrap && last_ring)) begin
                    fin_next = 1'b1;
                end else if (wrap) begin
                    az_next = '0;
                    el_next = el_sum[hsvg_pkg::EL_W-1:0];
                end else begin
                    az_next = az_sum[hsvg_pkg::AZ_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= hsvg_pkg::ST_IDLE;
            step_reg    <= '0;
            az_step_reg <= hsvg_pkg::AZ_W'(hsvg_pkg::STEP_RESET);
            el_step_reg <= hsvg_pkg::EL_W'(hsvg_pkg::STEP_RESET);
            az_reg      <= '0;
            el_reg      <= '0;
            fin_reg     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            az_step_reg <= az_step_next;
            el_step_reg <= el_step_next;
            az_reg      <= az_next;
            el_reg      <= el_next;
            fin_reg     <= fin_next;
        end
    end

    // Select angle and first operand for this step
    always_comb begin
        angle_sel = hsvg_pkg::ANGLE_W'(phi_reg);
        mul_a     = hsvg_pkg::RS_W'(hsvg_pkg::SPHERE_RADIUS);
        neg_mod   = 1'b0;
        unique case (step_reg)
            hsvg_pkg::STEP_R_SA: begin
                angle_sel = hsvg_pkg::ANGLE_W'(theta_reg);
            end
            hsvg_pkg::STEP_R_CA: begin
                angle_sel = hsvg_pkg::ANGLE_W'(theta_reg)
                          + hsvg_pkg::ANGLE_W'(hsvg_pkg::QUARTER_TURN);
            end
            hsvg_pkg::STEP_Z_LO: begin
                angle_sel = hsvg_pkg::ANGLE_W'(phi_reg)
                          + hsvg_pkg::ANGLE_W'(hsvg_pkg::QUARTER_TURN);
            end
            hsvg_pkg::STEP_Z_HI: begin
                angle_sel = hsvg_pkg::ANGLE_W'(phi2_reg)
                          + hsvg_pkg::ANGLE_W'(hsvg_pkg::QUARTER_TURN);
            end
            hsvg_pkg::STEP_X_LO: begin
                mul_a   = rsa_reg;
                neg_mod = na_reg;
            end
            hsvg_pkg::STEP_Y_LO: begin
                mul_a   = rca_reg;
                neg_mod = nc_reg;
            end
            hsvg_pkg::STEP_X_HI: begin
                angle_sel = hsvg_pkg::ANGLE_W'(phi2_reg);
                mul_a     = rsa_reg;
                neg_mod   = na_reg;
            end
            hsvg_pkg::STEP_Y_HI: begin
                angle_sel = hsvg_pkg::ANGLE_W'(phi2_reg);
                mul_a     = rca_reg;
                neg_mod   = nc_reg;
            end
            default: begin
                mul_a = rca_reg;
            end
        endcase
    end

    assign sine       = hsvg_pkg::sine_lookup(angle_sel);
    assign mul_prod   = hsvg_pkg::PROD_W'(mul_a) * hsvg_pkg::PROD_W'(sine.mag);
    // product registered last step was a z term when this step is Z_HI or X_LO
    assign coord_is_z = (step_reg == hsvg_pkg::STEP_Z_HI) || (step_reg == hsvg_pkg::STEP_X_LO);
    assign coord      = hsvg_pkg::to_coord(prod_reg, coord_is_z, prod_neg_reg);

    // Latch request, run the shared multiplier, route each product
    always_ff @(posedge aclk) begin
        if (emit) begin
            theta_reg <= az_eff;
            phi_reg   <= el_eff;
            phi2_reg  <= el_sum[hsvg_pkg::EL_W-1:0];
            done_reg  <= wrap && last_ring;
        end
        if (state_reg == hsvg_pkg::ST_CALC) begin
            prod_reg     <= mul_prod;
            prod_neg_reg <= sine.neg ^ neg_mod;
            if (step_reg == hsvg_pkg::STEP_R_SA) begin
                tex_s_reg  <= hsvg_pkg::tex_s_of(theta_reg);
                tex_t0_reg <= hsvg_pkg::TEX_T_ROM[phi_reg];
                tex_t1_reg <= hsvg_pkg::TEX_T_ROM[phi2_reg];
            end
            case (step_reg)
                hsvg_pkg::STEP_R_CA: begin
                    rsa_reg <= prod_reg[hsvg_pkg::RS_W-1:0];
                    na_reg  <= prod_neg_reg;
                end
                hsvg_pkg::STEP_Z_LO: begin
                    rca_reg <= prod_reg[hsvg_pkg::RS_W-1:0];
                    nc_reg  <= prod_neg_reg;
                end
                hsvg_pkg::STEP_Z_HI:  z0_reg <= coord;
                hsvg_pkg::STEP_X_LO:  z1_reg <= coord;
                hsvg_pkg::STEP_Y_LO:  x0_reg <= coord;
                hsvg_pkg::STEP_X_HI:  y0_reg <= coord;
                hsvg_pkg::STEP_Y_HI:  x1_reg <= coord;
                hsvg_pkg::STEP_DRAIN: y1_reg <= coord;
                default: ;
            endcase
        end
    end

`ifndef SYNTHESIS
    // never take a request while a vertex is on offer
    a_ready_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("request ready while vertex valid");

    // the sequencer never runs past its last step
    a_step_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == hsvg_pkg::ST_CALC) |-> (step_reg <= hsvg_pkg::STEP_DRAIN))
        else $error("step counter out of range");

    // lower vertex taken: upper vertex follows with the same done mark
    a_pair_follow: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=> (m_tvalid && m_tlast && $stable(m_tuser)))
        else $error("pair broken");

    // upper vertex taken: back to accepting requests
    a_pair_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> s_tready)
        else $error("not idle after pair");
`endif

endmodule

`default_nettype wire
